// File: rtl/core/prr_pkg.sv
// shared types, constants and widths for the pole-placement regulator step
`timescale 1ns / 1ps

package prr_pkg;

  // default arithmetic format, signed Q16.16 in 32-bit words
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // multiplier digit width, one digit of the second operand per cycle
  localparam int MUL_DIGIT = 16;

  // external field widths
  localparam int TS_WIDTH    = 17;
  localparam int VAL_WIDTH   = 32;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 4;

  // configuration register indexes
  localparam logic [1:0] REG_R0 = 2'd0;
  localparam logic [1:0] REG_R1 = 2'd1;
  localparam logic [1:0] REG_C0 = 2'd2;
  localparam logic [1:0] REG_C1 = 2'd3;

  // reset value of the derivative terms, 1.0 in Q16.16
  localparam logic signed [VAL_WIDTH-1:0] COEF_ONE = 32'sd65536;

  // operation of the shared arithmetic unit
  typedef enum logic {
    OP_MUL,
    OP_DIV
  } prr_op_e;

  // regulator coefficients as written over the register port
  typedef struct packed {
    logic signed [VAL_WIDTH-1:0] r0;
    logic signed [VAL_WIDTH-1:0] r1;
    logic signed [VAL_WIDTH-1:0] c0;
    logic signed [VAL_WIDTH-1:0] c1;
  } prr_coef_t;

  // input transaction payload
  typedef struct packed {
    logic [TS_WIDTH-1:0]         time_step;
    logic signed [VAL_WIDTH-1:0] setpoint;
    logic signed [VAL_WIDTH-1:0] measurement;
  } prr_in_t;

  // output transaction payload
  typedef struct packed {
    logic signed [VAL_WIDTH-1:0] command;
    logic                        div_error;
  } prr_out_t;

endpackage

// File: rtl/core/pole_placement_regulator_step.sv
// top level: regulator step sequencer, state and handshakes
`timescale 1ns / 1ps

// Pole-placement regulator step. Each input transaction (time step, setpoint,
// measurement) runs a first-order setpoint prefilter, forms the error, passes
// it through a lead-lag stage discretized by backward Euler and integrates the
// result into the drive command; one output transaction follows each input.
// Arithmetic is signed fixed point (DATA_WIDTH-bit words, FRAC_BITS fraction
// bits), saturating everywhere. If r1 + r0*dt or c1 + c0*dt is zero the state
// is left unchanged, the held command is returned and div_error is set.
// All multiplies and divides go through one shared unit (adds and subtracts are
// done in the sequencer), by default in 32-bit Q16.16: a multiply steps through
// NDIG 16-bit digits of the second operand (NDIG = DATA_WIDTH/16 rounded up),
// a divide through DATA_WIDTH+FRAC_BITS quotient bits, one quotient bit per cycle.
// A step is 8 multiplies and 2 divides; a zero-divisor step ends after 2 multiplies.
// in_ready_o is high only between steps. Coefficients sit at APB byte
// addresses 0x0 (r0), 0x4 (r1), 0x8 (c0), 0xC (c1), reset to 0, 1.0, 0, 1.0,
// and the user must write them only while no step is in progress; the block does not enforce this.
module pole_placement_regulator_step
  import prr_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  prr_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output prr_out_t              out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int DW = DATA_WIDTH;
  localparam int XW = ((DW > VAL_WIDTH) ? DW : VAL_WIDTH) + 1;

  localparam logic signed [XW-1:0] WMAX_X = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [XW-1:0] WMIN_X = ~WMAX_X;
  localparam logic signed [XW-1:0] VMAX_X = {{(XW-VAL_WIDTH+1){1'b0}}, {(VAL_WIDTH-1){1'b1}}};
  localparam logic signed [XW-1:0] VMIN_X = ~VMAX_X;
  localparam logic signed [DW-1:0] WMAX   = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] WMIN   = {1'b1, {(DW-1){1'b0}}};

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  // arithmetic steps of one regulator update
  localparam logic [3:0] STEP_R0DT = 4'd0;
  localparam logic [3:0] STEP_C0DT = 4'd1;
  localparam logic [3:0] STEP_AP   = 4'd2;
  localparam logic [3:0] STEP_BP   = 4'd3;
  localparam logic [3:0] STEP_PRE  = 4'd4;
  localparam logic [3:0] STEP_AE   = 4'd5;
  localparam logic [3:0] STEP_BE   = 4'd6;
  localparam logic [3:0] STEP_CL   = 4'd7;
  localparam logic [3:0] STEP_LL   = 4'd8;
  localparam logic [3:0] STEP_INT  = 4'd9;

  // saturate a widened value to the word width
  function automatic logic signed [DW-1:0] sat_dw(input logic signed [XW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > WMAX_X) begin
      r = WMAX;
    end else if (v < WMIN_X) begin
      r = WMIN;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  // saturate a widened value to the 32-bit output field
  function automatic logic signed [VAL_WIDTH-1:0] sat_val(input logic signed [XW-1:0] v);
    logic signed [VAL_WIDTH-1:0] r;
    if (v > VMAX_X) begin
      r = VMAX_X[VAL_WIDTH-1:0];
    end else if (v < VMIN_X) begin
      r = VMIN_X[VAL_WIDTH-1:0];
    end else begin
      r = v[VAL_WIDTH-1:0];
    end
    return r;
  endfunction

  // saturating add and subtract
  function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    return (s[DW] != s[DW-1]) ? (s[DW] ? WMIN : WMAX) : s[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] ssub(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    return (s[DW] != s[DW-1]) ? (s[DW] ? WMIN : WMAX) : s[DW-1:0];
  endfunction

  prr_coef_t coef;

  logic [1:0] state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       err_q;
  logic       out_valid_q;
  prr_out_t   out_data_q;
  logic       in_fire, out_load;

  // regulator state
  logic signed [DW-1:0] pre_prev_q, err_prev_q, ll_prev_q, integ_q;

  // step operands and temporaries
  logic signed [DW-1:0] dt_q, sp_q, meas_q;
  logic signed [DW-1:0] r0dt_q, den1_q, den2_q, acc_q, pre_q, e_q, ll_q;

  // coefficients at word width
  logic signed [DW-1:0] r0_s, r1_s, c0_s, c1_s;

  // shared unit hookup
  logic                 u_start, u_done;
  prr_op_e              u_op;
  logic signed [DW-1:0] u_a, u_b, u_res;
  logic signed [DW-1:0] den2_new;
  logic                 den_zero;

  prr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef)
  );

  prr_muldiv #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (u_start),
    .op_i     (u_op),
    .a_i      (u_a),
    .b_i      (u_b),
    .done_o   (u_done),
    .result_o (u_res)
  );

  always_comb begin
    r0_s = sat_dw(XW'(coef.r0));
    r1_s = sat_dw(XW'(coef.r1));
    c0_s = sat_dw(XW'(coef.c0));
    c1_s = sat_dw(XW'(coef.c1));
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // zero divisor check once both denominators are known
  assign den2_new = sadd(c1_s, u_res);
  assign den_zero = (den1_q == '0) || (den2_new == '0);

  // operand select for each step
  always_comb begin
    u_op = OP_MUL;
    u_a  = '0;
    u_b  = '0;
    case (step_q)
      STEP_R0DT: begin u_a = r0_s;   u_b = dt_q;       end
      STEP_C0DT: begin u_a = c0_s;   u_b = dt_q;       end
      STEP_AP:   begin u_a = r0dt_q; u_b = sp_q;       end
      STEP_BP:   begin u_a = r1_s;   u_b = pre_prev_q; end
      STEP_PRE:  begin u_op = OP_DIV; u_a = acc_q; u_b = den1_q; end
      STEP_AE:   begin u_a = den1_q; u_b = e_q;        end
      STEP_BE:   begin u_a = r1_s;   u_b = err_prev_q; end
      STEP_CL:   begin u_a = c1_s;   u_b = ll_prev_q;  end
      STEP_LL:   begin u_op = OP_DIV; u_a = acc_q; u_b = den2_q; end
      STEP_INT:  begin u_a = dt_q;   u_b = ll_q;       end
      default:   ;
    endcase
  end

  // step sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    u_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_ISSUE;
          step_d  = STEP_R0DT;
        end
      end
      ST_ISSUE: begin
        u_start = 1'b1;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (u_done) begin
          if ((step_q == STEP_C0DT && den_zero) || step_q == STEP_INT) begin
            state_d = ST_OUT;
          end else begin
            step_d  = step_q + 4'd1;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control and regulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_R0DT;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      pre_prev_q  <= '0;
      err_prev_q  <= '0;
      ll_prev_q   <= '0;
      integ_q     <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (in_fire) begin
        err_q <= 1'b0;
      end else if (state_q == ST_WAIT && u_done && step_q == STEP_C0DT && den_zero) begin
        err_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // commit the update after the integrator step
      if (state_q == ST_WAIT && u_done && step_q == STEP_INT) begin
        integ_q    <= sadd(u_res, integ_q);
        pre_prev_q <= pre_q;
        err_prev_q <= e_q;
        ll_prev_q  <= ll_q;
      end
    end
  end

  // input capture and step temporaries
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dt_q   <= sat_dw(XW'($signed({1'b0, in_data_i.time_step})));
      sp_q   <= sat_dw(XW'(in_data_i.setpoint));
      meas_q <= sat_dw(XW'(in_data_i.measurement));
    end
    if (state_q == ST_WAIT && u_done) begin
      case (step_q)
        STEP_R0DT: begin
          r0dt_q <= u_res;
          den1_q <= sadd(r1_s, u_res);
        end
        STEP_C0DT: den2_q <= den2_new;
        STEP_AP:   acc_q  <= u_res;
        STEP_BP:   acc_q  <= sadd(acc_q, u_res);
        STEP_PRE: begin
          pre_q <= u_res;
          e_q   <= ssub(u_res, meas_q);
        end
        STEP_AE:   acc_q  <= u_res;
        STEP_BE:   acc_q  <= ssub(acc_q, u_res);
        STEP_CL:   acc_q  <= sadd(acc_q, u_res);
        STEP_LL:   ll_q   <= u_res;
        default:   ;
      endcase
    end
    if (out_load) begin
      out_data_q.command   <= sat_val(XW'(integ_q));
      out_data_q.div_error <= err_q;
    end
  end

`ifndef NO_ASSERTIONS
  // an accepted transaction starts the first arithmetic step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_ISSUE && step_q == STEP_R0DT))
    else $error("accepted transaction did not start the step sequence");

  // the shared unit only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_done |-> (state_q == ST_WAIT))
    else $error("arithmetic unit finished outside a wait state");

  // a zero divisor leaves the integrator untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && err_q) |-> $stable(integ_q))
    else $error("integrator changed on a zero divisor step");
`endif

endmodule

// File: rtl/core/prr_cfg.sv
// apb register file holding the four regulator coefficients
`timescale 1ns / 1ps

module prr_cfg
  import prr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output prr_coef_t             coef_o
);

  prr_coef_t  coef_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;
  assign coef_o  = coef_q;

  // register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.r0 <= '0;
      coef_q.r1 <= COEF_ONE;
      coef_q.c0 <= '0;
      coef_q.c1 <= COEF_ONE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_R0:  coef_q.r0 <= pwdata;
        REG_R1:  coef_q.r1 <= pwdata;
        REG_C0:  coef_q.c0 <= pwdata;
        REG_C1:  coef_q.c1 <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_R0:  prdata = coef_q.r0;
      REG_R1:  prdata = coef_q.r1;
      REG_C0:  prdata = coef_q.c0;
      REG_C1:  prdata = coef_q.c1;
      default: prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/prr_muldiv.sv
// shared multi-cycle unit: fixed-point multiply and divide with saturation
`timescale 1ns / 1ps

module prr_muldiv
  import prr_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  prr_op_e                      op_i,
  input  logic signed [DATA_WIDTH-1:0] a_i,
  input  logic signed [DATA_WIDTH-1:0] b_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] result_o
);

  localparam int DW   = DATA_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int NDIG = (DW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int YW   = NDIG * MUL_DIGIT;
  localparam int PW   = DW + YW;
  localparam int QW   = DW + FB;
  localparam int CW   = $clog2(QW);

  localparam logic [1:0] US_IDLE = 2'd0;
  localparam logic [1:0] US_MUL  = 2'd1;
  localparam logic [1:0] US_DIV  = 2'd2;
  localparam logic [1:0] US_FIN  = 2'd3;

  localparam logic signed [DW-1:0] WMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] WMIN = {1'b1, {(DW-1){1'b0}}};

  logic [1:0]    ustate_q, ustate_d;
  logic [CW-1:0] cnt_q, cnt_d;
  prr_op_e       op_q;
  logic          done_q;
  logic          neg_q;

  logic [DW-1:0] x_q;
  logic [YW-1:0] y_q;
  logic [PW-1:0] acc_q;
  logic [DW-1:0] d_q;
  logic [DW-1:0] rem_q;
  logic [QW-1:0] dq_q;
  logic signed [DW-1:0] res_q;

  logic [DW-1:0]           mag_a, mag_b;
  logic [DW+MUL_DIGIT-1:0] pp;
  logic [PW-1:0]           acc_d;
  logic [DW:0]             rr, rsub;
  logic                    ge;
  logic [DW-1:0]           rem_d;
  logic [QW-1:0]           dq_d;
  logic signed [2*DW:0]    mps, msh;
  logic signed [QW:0]      qs;
  logic                    m_ok, q_ok;
  logic signed [DW-1:0]    res_m, res_q_div, res_d;

  assign done_o   = done_q;
  assign result_o = res_q;

  // operand magnitudes
  always_comb begin
    mag_a = a_i[DW-1] ? (~a_i) + DW'(1) : a_i;
    mag_b = b_i[DW-1] ? (~b_i) + DW'(1) : b_i;
  end

  // multiply step: one digit of the second operand, most significant first
  always_comb begin
    pp    = x_q * y_q[YW-1 -: MUL_DIGIT];
    acc_d = (acc_q << MUL_DIGIT) + PW'(pp);
  end

  // restoring divide step: one quotient bit
  always_comb begin
    rr    = {rem_q, dq_q[QW-1]};
    rsub  = rr - {1'b0, d_q};
    ge    = (rr >= {1'b0, d_q});
    rem_d = ge ? rsub[DW-1:0] : rr[DW-1:0];
    dq_d  = {dq_q[QW-2:0], ge};
  end

  // sign, scale and saturate the finished value
  always_comb begin
    mps   = neg_q ? -$signed({1'b0, acc_q[2*DW-1:0]}) : $signed({1'b0, acc_q[2*DW-1:0]});
    msh   = mps >>> FB;
    m_ok  = (&msh[2*DW:DW-1]) | ~(|msh[2*DW:DW-1]);
    res_m = m_ok ? msh[DW-1:0] : (msh[2*DW] ? WMIN : WMAX);

    qs        = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
    q_ok      = (&qs[QW:DW-1]) | ~(|qs[QW:DW-1]);
    res_q_div = q_ok ? qs[DW-1:0] : (qs[QW] ? WMIN : WMAX);

    res_d = (op_q == OP_MUL) ? res_m : res_q_div;
  end

  // sequencer of the unit
  always_comb begin
    ustate_d = ustate_q;
    cnt_d    = cnt_q;
    case (ustate_q)
      US_IDLE: begin
        if (start_i) begin
          ustate_d = (op_i == OP_MUL) ? US_MUL : US_DIV;
          cnt_d    = '0;
        end
      end
      US_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(NDIG - 1)) begin
          ustate_d = US_FIN;
        end
      end
      US_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(QW - 1)) begin
          ustate_d = US_FIN;
        end
      end
      US_FIN: begin
        ustate_d = US_IDLE;
      end
      default: ustate_d = US_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ustate_q <= US_IDLE;
      cnt_q    <= '0;
      op_q     <= OP_MUL;
      done_q   <= 1'b0;
    end else begin
      ustate_q <= ustate_d;
      cnt_q    <= cnt_d;
      done_q   <= (ustate_q == US_FIN);
      if (ustate_q == US_IDLE && start_i) begin
        op_q <= op_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (ustate_q)
      US_IDLE: begin
        if (start_i) begin
          x_q   <= mag_a;
          y_q   <= YW'(mag_b);
          acc_q <= '0;
          d_q   <= mag_b;
          rem_q <= '0;
          dq_q  <= {mag_a, {FB{1'b0}}};
          neg_q <= a_i[DW-1] ^ b_i[DW-1];
        end
      end
      US_MUL: begin
        acc_q <= acc_d;
        y_q   <= y_q << MUL_DIGIT;
      end
      US_DIV: begin
        rem_q <= rem_d;
        dq_q  <= dq_d;
      end
      US_FIN: begin
        res_q <= res_d;
      end
      default: ;
    endcase
  end

endmodule

// File: tb/tb_pole_placement_regulator_step.sv
// testbench for the regulator step: directed and random transactions checked against a predictor
`timescale 1ns / 1ps

module tb_pole_placement_regulator_step;
  import prr_pkg::*;

  localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] ONE     = COEF_ONE;
  localparam logic [31:0] HALF    = 32'h0000_8000;
  localparam logic [31:0] QUARTER = 32'h0000_4000;
  localparam logic [31:0] TWO     = 32'h0002_0000;
  localparam logic [31:0] NEG_ONE = 32'hffff_0000;
  localparam logic [31:0] NEG_QTR = 32'hffff_c000;

  // predicts the drive command of each step and checks the block's results
  class regulator_shadow;
    longint r0, r1, c0, c1;
    longint prefilt, err_last, leadlag, integ;
    prr_out_t pending[$];
    int mismatches;

    function new();
      r0 = 0;
      r1 = longint'($signed(COEF_ONE));
      c0 = 0;
      c1 = longint'($signed(COEF_ONE));
      prefilt = 0;
      err_last = 0;
      leadlag = 0;
      integ = 0;
      mismatches = 0;
    endfunction

    function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Q16.16 product, floor rounding
    function longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      return clamp(p >>> FRAC_BITS_DEF);
    endfunction

    // Q16.16 quotient, truncated toward zero
    function longint qdiv(longint n, longint d);
      longint q;
      q = (n <<< FRAC_BITS_DEF) / d;
      return clamp(q);
    endfunction

    function void set_coef(logic [1:0] idx, logic [31:0] val);
      longint v;
      v = longint'($signed(val));
      case (idx)
        REG_R0: r0 = v;
        REG_R1: r1 = v;
        REG_C0: c0 = v;
        REG_C1: c1 = v;
        default: ;
      endcase
    endfunction

    // one regulator step: prefilter, error, lead-lag, integrator
    function void accept_step(prr_in_t it);
      longint dt, sp, meas, r0dt, den1, den2, pre, e, num2, ll;
      bit zero_div;
      prr_out_t res;
      dt = longint'(it.time_step);
      sp = longint'($signed(it.setpoint));
      meas = longint'($signed(it.measurement));
      r0dt = qmul(r0, dt);
      den1 = clamp(r1 + r0dt);
      den2 = clamp(c1 + qmul(c0, dt));
      zero_div = (den1 == 0) || (den2 == 0);
      if (!zero_div) begin
        pre = qdiv(clamp(qmul(r0dt, sp) + qmul(r1, prefilt)), den1);
        e = clamp(pre - meas);
        num2 = clamp(qmul(den1, e) - qmul(r1, err_last));
        ll = qdiv(clamp(num2 + qmul(c1, leadlag)), den2);
        integ = clamp(qmul(dt, ll) + integ);
        prefilt = pre;
        err_last = e;
        leadlag = ll;
      end
      res.command = integ[31:0];
      res.div_error = zero_div;
      pending.push_back(res);
    endfunction

    function void check_cmd(prr_out_t got);
      prr_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, command %0d div_error %0b", $time,
                 $signed(got.command), got.div_error);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.command !== want.command) begin
        $display("%0t: command expected %0d actual %0d", $time,
                 $signed(want.command), $signed(got.command));
        mismatches++;
      end
      if (got.div_error !== want.div_error) begin
        $display("%0t: div_error expected %0b actual %0b", $time,
                 want.div_error, got.div_error);
        mismatches++;
      end
    endfunction

    function int waiting();
      return pending.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  prr_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  prr_out_t              out_data_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  regulator_shadow shadow;
  bit no_idle = 1'b0;

  pole_placement_regulator_step u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #2 clk_i = ~clk_i;

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return 32'($urandom_range(0, 13107200)) - 32'd6553600;
  endfunction

  function automatic logic [31:0] pick_coef(bit deriv);
    case ($urandom_range(0, 19))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return $urandom;
      4: return -32'($urandom_range(1, 131072));
      default: return deriv ? 32'($urandom_range(32768, 131072))
                            : 32'($urandom_range(0, 655360));
    endcase
  endfunction

  function automatic prr_in_t make_item();
    prr_in_t it;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) it.time_step = 17'($urandom_range(0, 131071));
    else if (sel == 1) it.time_step = 17'd65536;
    else it.time_step = 17'($urandom_range(1, 6554));
    it.setpoint = pick_value();
    it.measurement = pick_value();
    return it;
  endfunction

  // transaction monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) shadow.accept_step(in_data_i);
      if (out_valid_o && out_ready_i) shadow.check_cmd(out_data_o);
    end
  end

  // receiver: ready runs broken by random stalls
  initial begin
    int run;
    int gap;
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      run = $urandom_range(1, 300);
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // send one input transaction, holding it until accepted
  task automatic drive_item(input prr_in_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_step(input logic [16:0] dt, input logic [31:0] sp,
                           input logic [31:0] meas);
    prr_in_t it;
    it.time_step = dt;
    it.setpoint = sp;
    it.measurement = meas;
    drive_item(it);
  endtask

  // wait until every expected result has come back, first letting the
  // monitor note the last accepted transaction
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (shadow.waiting() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // setup and access cycle; psel stays high for a following write
  task automatic write_coef(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    shadow.set_coef(idx, val);
  endtask

  task automatic apply_coefs(input logic [31:0] r0, input logic [31:0] r1,
                             input logic [31:0] c0, input logic [31:0] c1);
    drain();
    write_coef(REG_R0, r0);
    write_coef(REG_R1, r1);
    write_coef(REG_C0, c0);
    write_coef(REG_C1, c1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // main sequence
  initial begin
    shadow = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients, extremes of every field
    send_step(17'd1, 32'd0, 32'd0);
    send_step(17'd65536, VAL_MAX, VAL_MIN);
    send_step(17'd0, VAL_MIN, VAL_MAX);
    send_step(17'h1ffff, VAL_MAX, VAL_MAX);
    send_step(17'd32768, ONE, NEG_ONE);

    // ordinary coefficients
    apply_coefs(TWO, ONE, ONE, HALF);
    send_step(17'd6554, 32'h000a_0000, 32'd0);
    send_step(17'h1ffff, VAL_MIN, 32'h0001_8000);
    send_step(17'd0, VAL_MAX, VAL_MIN);
    send_step(17'd65536, 32'hfff6_0000, 32'h0000_1234);
    send_step(17'd327, 32'd0, VAL_MAX);

    // zero prefilter divisor from zero coefficients
    apply_coefs('0, '0, ONE, ONE);
    send_step(17'd65536, ONE, 32'd0);
    send_step(17'd0, VAL_MAX, VAL_MIN);

    // zero divisors from cancelling terms: first one, then the other
    apply_coefs(TWO, NEG_ONE, ONE, NEG_QTR);
    send_step(17'd32768, ONE, HALF);
    send_step(17'd16384, ONE, HALF);
    send_step(17'd65536, ONE, HALF);

    // extreme coefficients
    apply_coefs(VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX);
    send_step(17'd65536, VAL_MAX, VAL_MIN);
    send_step(17'd1, VAL_MIN, VAL_MAX);
    send_step(17'h1ffff, ONE, QUARTER);

    // random phases, each with its own coefficient setting
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) apply_coefs(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
      else if (ph == 1) apply_coefs(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
      else apply_coefs(pick_coef(1'b0), pick_coef(1'b1), pick_coef(1'b0), pick_coef(1'b1));
      no_idle = (ph == 3);
      repeat (62) drive_item(make_item());
    end
    no_idle = 1'b0;

    drain();
    repeat (600) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.waiting() == 0) begin
      $display("tb_pole_placement_regulator_step OK");
    end else begin
      $display("tb_pole_placement_regulator_step NOT OK");
    end
    $finish;
  end

  // hang guard
  initial begin
    #10_000_000;
    $display("tb_pole_placement_regulator_step NOT OK");
    $finish;
  end

endmodule
